FILE: rtl/sct_pkg.sv
// shared types, codes and helper functions of the shell command tokenizer
package sct_pkg;

  localparam int MAX_WORD  = 255;
  localparam int WLEN_W    = $clog2(MAX_WORD + 1);
  localparam int MAX_RES   = 4;
  localparam int RES_IDX_W = $clog2(MAX_RES);
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PIPE   = 8'h7c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;

  typedef enum logic [3:0] {
    K_WBYTE   = 4'd0,
    K_WEND    = 4'd1,
    K_AND     = 4'd2,
    K_AMP     = 4'd3,
    K_OR      = 4'd4,
    K_PIPE    = 4'd5,
    K_SEMI    = 4'd6,
    K_LPAR    = 4'd7,
    K_RPAR    = 4'd8,
    K_GTGT    = 4'd9,
    K_GT      = 4'd10,
    K_HEREDOC = 4'd11,
    K_LT      = 4'd12,
    K_EOF     = 4'd13
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_AMP  = 3'd1,
    OP_PIPE = 3'd2,
    OP_GT   = 3'd3,
    OP_LT   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       trunc;
  } tok_t;

  // all results of one item, in order
  typedef struct packed {
    tok_t [MAX_RES-1:0]   toks;
    logic [RES_CNT_W-1:0] cnt;
  } bundle_t;

  function automatic bundle_t push_tok(bundle_t b, kind_t k, logic [7:0] c, logic t);
    bundle_t r;
    r = b;
    if (r.cnt < RES_CNT_W'(MAX_RES)) begin
      r.toks[r.cnt[RES_IDX_W-1:0]] = '{kind: k, ch: c, trunc: t};
      r.cnt = r.cnt + RES_CNT_W'(1);
    end
    return r;
  endfunction

  function automatic logic [7:0] pair_char(op_t op);
    logic [7:0] r;
    case (op)
      OP_AMP:  r = CH_AMP;
      OP_PIPE: r = CH_PIPE;
      OP_GT:   r = CH_GT;
      OP_LT:   r = CH_LT;
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

  function automatic kind_t single_kind(op_t op);
    kind_t r;
    case (op)
      OP_AMP:  r = K_AMP;
      OP_PIPE: r = K_PIPE;
      OP_GT:   r = K_GT;
      default: r = K_LT;
    endcase
    return r;
  endfunction

  function automatic kind_t double_kind(op_t op);
    kind_t r;
    case (op)
      OP_AMP:  r = K_AND;
      OP_PIPE: r = K_OR;
      OP_GT:   r = K_GTGT;
      default: r = K_HEREDOC;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/sct_in_if.sv
// input channel: one line byte per item
interface sct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       char_valid;
  logic       line_end;

  modport source(output valid, output char_in, output char_valid, output line_end,
                 input ready);
  modport sink(input valid, input char_in, input char_valid, input line_end,
               output ready);
endinterface

FILE: rtl/sct_out_if.sv
// output channel: one token result per item
interface sct_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [7:0] char_out;
  logic       truncated;
  logic       last;

  modport source(output valid, output kind, output char_out, output truncated,
                 output last, input ready);
  modport sink(input valid, input kind, input char_out, input truncated,
               input last, output ready);
endinterface

FILE: rtl/sct_front.sv
// lexer front: classifies each byte, updates lexer state, builds the result bundle
module sct_front (
  input  logic            clk,
  input  logic            rst,
  sct_in_if.sink          char_ch,
  input  logic            q_full,
  output logic            q_push,
  output sct_pkg::bundle_t q_data
);

  sct_pkg::quote_t             quote_mode, quote_mode_next;
  logic                        escape_pending, escape_pending_next;
  sct_pkg::op_t                pend_op, pend_op_next;
  logic                        word_open, word_open_next;
  logic [sct_pkg::WLEN_W-1:0]  word_len, word_len_next;
  logic                        word_trunc, word_trunc_next;
  logic                        line_done, line_done_next;

  sct_pkg::bundle_t bundle;
  logic [7:0]       c;
  logic             accept;
  logic             is_nul;
  logic             finish;
  logic             wb;
  logic             handled;
  logic             blank, punct, opchar;

  assign c             = char_ch.char_in;
  assign char_ch.ready = !q_full;
  assign accept        = char_ch.valid && char_ch.ready;
  assign is_nul        = char_ch.char_valid && (c == sct_pkg::CH_NUL);
  assign finish        = char_ch.line_end || is_nul;

  assign blank  = (c inside {[sct_pkg::CH_TAB:sct_pkg::CH_CR], sct_pkg::CH_SPACE});
  assign punct  = (c inside {sct_pkg::CH_SEMI, sct_pkg::CH_LPAR, sct_pkg::CH_RPAR});
  assign opchar = (c inside {sct_pkg::CH_AMP, sct_pkg::CH_PIPE, sct_pkg::CH_GT,
                             sct_pkg::CH_LT});

  always_comb begin
    quote_mode_next     = quote_mode;
    escape_pending_next = escape_pending;
    pend_op_next        = pend_op;
    word_open_next      = word_open;
    word_len_next       = word_len;
    word_trunc_next     = word_trunc;
    line_done_next      = line_done;
    bundle              = '0;
    wb                  = 1'b0;
    handled             = 1'b0;

    if (line_done) begin
      // rest of line after a nul byte is dropped
      if (char_ch.line_end) begin
        line_done_next = 1'b0;
      end
    end else begin
      if (char_ch.char_valid && !is_nul) begin
        if (quote_mode == sct_pkg::Q_SINGLE) begin
          if (c == sct_pkg::CH_SQUOTE) begin
            quote_mode_next = sct_pkg::Q_NONE;
          end else begin
            wb = 1'b1;
          end
        end else if (quote_mode == sct_pkg::Q_DOUBLE) begin
          if (escape_pending) begin
            wb                  = 1'b1;
            escape_pending_next = 1'b0;
          end else if (c == sct_pkg::CH_BSLASH) begin
            escape_pending_next = 1'b1;
          end else if (c == sct_pkg::CH_DQUOTE) begin
            quote_mode_next = sct_pkg::Q_NONE;
          end else begin
            wb = 1'b1;
          end
        end else begin
          quote_mode_next = sct_pkg::Q_NONE;
          if (escape_pending) begin
            wb                  = 1'b1;
            escape_pending_next = 1'b0;
          end else begin
            if (pend_op != sct_pkg::OP_NONE) begin
              if (c == sct_pkg::pair_char(pend_op)) begin
                bundle  = sct_pkg::push_tok(bundle, sct_pkg::double_kind(pend_op), 8'h00,
                                            1'b0);
                handled = 1'b1;
              end else begin
                bundle = sct_pkg::push_tok(bundle, sct_pkg::single_kind(pend_op), 8'h00,
                                           1'b0);
              end
            end
            pend_op_next = sct_pkg::OP_NONE;
            if (!handled) begin
              if (blank || punct || opchar) begin
                // word end
                if (word_open_next) begin
                  bundle = sct_pkg::push_tok(bundle, sct_pkg::K_WEND, 8'h00, word_trunc_next);
                end
                word_open_next  = 1'b0;
                word_len_next   = '0;
                word_trunc_next = 1'b0;
              end
              if (punct) begin
                case (c)
                  sct_pkg::CH_SEMI:
                    bundle = sct_pkg::push_tok(bundle, sct_pkg::K_SEMI, 8'h00, 1'b0);
                  sct_pkg::CH_LPAR:
                    bundle = sct_pkg::push_tok(bundle, sct_pkg::K_LPAR, 8'h00, 1'b0);
                  default:
                    bundle = sct_pkg::push_tok(bundle, sct_pkg::K_RPAR, 8'h00, 1'b0);
                endcase
              end else if (opchar) begin
                case (c)
                  sct_pkg::CH_AMP:  pend_op_next = sct_pkg::OP_AMP;
                  sct_pkg::CH_PIPE: pend_op_next = sct_pkg::OP_PIPE;
                  sct_pkg::CH_GT:   pend_op_next = sct_pkg::OP_GT;
                  default:          pend_op_next = sct_pkg::OP_LT;
                endcase
              end else if (!blank) begin
                case (c)
                  sct_pkg::CH_SQUOTE: begin
                    word_open_next  = 1'b1;
                    quote_mode_next = sct_pkg::Q_SINGLE;
                  end
                  sct_pkg::CH_DQUOTE: begin
                    word_open_next  = 1'b1;
                    quote_mode_next = sct_pkg::Q_DOUBLE;
                  end
                  sct_pkg::CH_BSLASH: begin
                    word_open_next      = 1'b1;
                    escape_pending_next = 1'b1;
                  end
                  default: wb = 1'b1;
                endcase
              end
            end
          end
        end
        // word byte, dropped past the bound
        if (wb) begin
          word_open_next = 1'b1;
          if (word_len_next < sct_pkg::WLEN_W'(sct_pkg::MAX_WORD)) begin
            bundle        = sct_pkg::push_tok(bundle, sct_pkg::K_WBYTE, c, 1'b0);
            word_len_next = word_len_next + sct_pkg::WLEN_W'(1);
          end else begin
            word_trunc_next = 1'b1;
          end
        end
      end

      if (finish) begin
        // dangling backslash becomes a literal byte
        if (escape_pending_next) begin
          word_open_next = 1'b1;
          if (word_len_next < sct_pkg::WLEN_W'(sct_pkg::MAX_WORD)) begin
            bundle = sct_pkg::push_tok(bundle, sct_pkg::K_WBYTE, sct_pkg::CH_BSLASH, 1'b0);
          end else begin
            word_trunc_next = 1'b1;
          end
        end
        if (word_open_next) begin
          bundle = sct_pkg::push_tok(bundle, sct_pkg::K_WEND, 8'h00, word_trunc_next);
        end
        if (pend_op_next != sct_pkg::OP_NONE) begin
          bundle = sct_pkg::push_tok(bundle, sct_pkg::single_kind(pend_op_next), 8'h00, 1'b0);
        end
        bundle              = sct_pkg::push_tok(bundle, sct_pkg::K_EOF, 8'h00, 1'b0);
        quote_mode_next     = sct_pkg::Q_NONE;
        escape_pending_next = 1'b0;
        pend_op_next        = sct_pkg::OP_NONE;
        word_open_next      = 1'b0;
        word_len_next       = '0;
        word_trunc_next     = 1'b0;
        line_done_next      = is_nul && !char_ch.line_end;
      end
    end
  end

  assign q_push = accept && (bundle.cnt != '0);
  assign q_data = bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode     <= sct_pkg::Q_NONE;
      escape_pending <= 1'b0;
      pend_op        <= sct_pkg::OP_NONE;
      word_open      <= 1'b0;
      word_len       <= '0;
      word_trunc     <= 1'b0;
      line_done      <= 1'b0;
    end else if (accept) begin
      quote_mode     <= quote_mode_next;
      escape_pending <= escape_pending_next;
      pend_op        <= pend_op_next;
      word_open      <= word_open_next;
      word_len       <= word_len_next;
      word_trunc     <= word_trunc_next;
      line_done      <= line_done_next;
    end
  end

  a_line_done_clean: assert property (@(posedge clk) disable iff (rst)
    line_done |-> (quote_mode == sct_pkg::Q_NONE) && !word_open && !escape_pending &&
                  (pend_op == sct_pkg::OP_NONE))
    else $error("lexer state not cleared while skipping rest of line");

endmodule

FILE: rtl/sct_queue.sv
// short bundle queue between lexer front and result serializer
module sct_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sct_pkg::bundle_t wr_data,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output sct_pkg::bundle_t head
);

  sct_pkg::bundle_t            slots [sct_pkg::QDEPTH];
  logic [sct_pkg::QPTR_W-1:0]  wr_ptr;
  logic [sct_pkg::QPTR_W-1:0]  rd_ptr;
  logic [sct_pkg::QCNT_W-1:0]  count;

  assign full  = (count == sct_pkg::QCNT_W'(sct_pkg::QDEPTH));
  assign avail = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sct_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sct_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + sct_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - sct_pkg::QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> avail)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= sct_pkg::QCNT_W'(sct_pkg::QDEPTH))
    else $error("queue count out of range");

endmodule

FILE: rtl/sct_back.sv
// result serializer: walks one bundle a result per cycle while tok_ch is ready and marks the last
module sct_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_avail,
  input  sct_pkg::bundle_t q_head,
  output logic             q_pop,
  sct_out_if.source        tok_ch
);

  sct_pkg::bundle_t                cur;
  logic                            cur_valid;
  logic [sct_pkg::RES_IDX_W-1:0]   idx;
  sct_pkg::tok_t                   tok;
  logic                            is_last;
  logic                            done;
  logic                            load;

  assign tok     = cur.toks[idx];
  assign is_last = ({1'b0, idx} + sct_pkg::RES_CNT_W'(1)) == cur.cnt;
  assign done    = tok_ch.valid && tok_ch.ready && is_last;
  assign load    = !cur_valid || done;
  assign q_pop   = load && q_avail;

  assign tok_ch.valid     = cur_valid;
  assign tok_ch.kind      = tok.kind;
  assign tok_ch.char_out  = tok.ch;
  assign tok_ch.truncated = tok.trunc;
  assign tok_ch.last      = is_last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (done) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (tok_ch.valid && tok_ch.ready) begin
      idx <= idx + sct_pkg::RES_IDX_W'(1);
    end
  end

  a_bundle_nonempty: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.cnt != '0) && ({1'b0, idx} < cur.cnt))
    else $error("serializer index outside its bundle");

endmodule

FILE: rtl/shell_command_tokenizer.sv
// top level of the shell command tokenizer
//
// Lexes a command line fed one byte per item on char_ch and streams tokens on
// tok_ch. Outside quotes, blanks split words and && & || | ; ( ) >> > << < are
// recognized, with a one-operator hold register deciding two-byte forms on the
// next byte. Word bytes come out one per result as they arrive, a word end
// (with truncated set if bytes past the length bound were dropped) closes each
// word, and every line closes with an eof result; a nul byte ends the line
// early and the rest up to the line_end item is ignored. last marks the final
// result of each input item. Rate: the front takes one item per cycle while
// the queue is not full and turns it into a bundle of up to four results; a
// four-entry bundle queue feeds the serializer, which sends one result per
// cycle while tok_ch is ready. So items that each cause at most one result
// flow at one per cycle, an item causing k results holds the output for all k,
// and the queue absorbs bursts so that input stalls only once four bundles
// wait. An item's first result passes a queue slot, then the serializer register.
module shell_command_tokenizer (
  input  logic      clk,
  input  logic      rst,
  sct_in_if.sink    char_ch,
  sct_out_if.source tok_ch
);

  // front to queue
  logic             q_push;
  logic             q_full;
  sct_pkg::bundle_t q_wr;

  // queue to serializer
  logic             q_pop;
  logic             q_avail;
  sct_pkg::bundle_t q_head;

  sct_front u_front (
    .clk     (clk),
    .rst     (rst),
    .char_ch (char_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wr)
  );

  sct_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .avail   (q_avail),
    .head    (q_head)
  );

  sct_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_avail (q_avail),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .tok_ch  (tok_ch)
  );

endmodule

FILE: bench/tb_shell_command_tokenizer.sv
// self-checking testbench of the shell command tokenizer with its own token predictor
`timescale 1ns / 100ps

module tb_shell_command_tokenizer;

  // cycles with no item moving on either channel before the run is called hung
  localparam int WATCHDOG_LIMIT = 2000;
  // random input items wanted after the directed part
  localparam int RANDOM_ITEMS   = 150;
  // quiet cycles after the last token, enough for anything still in the pipe
  localparam int TAIL_CYCLES    = 20;
  localparam int MAX_REPORTS    = 100;

  // one expected token together with its end-of-item flag
  typedef struct packed {
    sct_pkg::tok_t tok;
    logic          last;
  } token_t;

  // one input item; a known row carries up to two tokens typed in by hand
  typedef struct packed {
    logic [7:0]    c;
    logic          cv;
    logic          le;
    logic          known;
    logic [1:0]    nknown;
    sct_pkg::tok_t k0;
    sct_pkg::tok_t k1;
  } row_t;

  localparam sct_pkg::tok_t NO_TOK = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sct_in_if  char_if ();
  sct_out_if tok_if ();

  shell_command_tokenizer i_dut (
    .clk    (clk),
    .rst    (rst),
    .char_ch(char_if),
    .tok_ch (tok_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lexer state of the predictor
  sct_pkg::quote_t lx_quote;
  logic            lx_esc;
  sct_pkg::op_t    lx_op;
  logic            lx_wopen;
  int              lx_wlen;
  logic            lx_wtrunc;
  logic            lx_skip;     // nul byte seen, ignoring up to line end

  sct_pkg::tok_t item_toks[$];   // tokens caused by the item being predicted
  token_t        tokens_due[$];  // tokens still to come out, oldest first
  row_t          line_q[$];      // items of the line being built

  int         err_count = 0;
  int         idle_cycles = 0;
  int         sink_hold = 0;
  bit         no_idle = 1'b0;

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("mismatch in %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
  endtask

  // ---------------------------------------------------------------------------
  // token predictor
  // ---------------------------------------------------------------------------

  function automatic sct_pkg::tok_t tok(sct_pkg::kind_t k, logic [7:0] b, logic t);
    sct_pkg::tok_t r;
    r.kind  = k;
    r.ch    = b;
    r.trunc = t;
    return r;
  endfunction

  // an item never causes more than MAX_RES tokens
  function automatic void put_tok(sct_pkg::kind_t k, logic [7:0] b, logic t);
    if (item_toks.size() < sct_pkg::MAX_RES)
      item_toks.push_back(tok(k, b, t));
  endfunction

  // bytes past the length bound are dropped and only remembered
  function automatic void add_word_byte(logic [7:0] b);
    lx_wopen = 1'b1;
    if (lx_wlen < sct_pkg::MAX_WORD) begin
      put_tok(sct_pkg::K_WBYTE, b, 1'b0);
      lx_wlen++;
    end else begin
      lx_wtrunc = 1'b1;
    end
  endfunction

  function automatic void close_word();
    if (lx_wopen)
      put_tok(sct_pkg::K_WEND, 8'h00, lx_wtrunc);
    lx_wopen  = 1'b0;
    lx_wlen   = 0;
    lx_wtrunc = 1'b0;
  endfunction

  function automatic sct_pkg::kind_t lone_op_kind(sct_pkg::op_t op);
    case (op)
      sct_pkg::OP_AMP:  return sct_pkg::K_AMP;
      sct_pkg::OP_PIPE: return sct_pkg::K_PIPE;
      sct_pkg::OP_GT:   return sct_pkg::K_GT;
      default:          return sct_pkg::K_LT;
    endcase
  endfunction

  function automatic sct_pkg::kind_t paired_op_kind(sct_pkg::op_t op);
    case (op)
      sct_pkg::OP_AMP:  return sct_pkg::K_AND;
      sct_pkg::OP_PIPE: return sct_pkg::K_OR;
      sct_pkg::OP_GT:   return sct_pkg::K_GTGT;
      default:          return sct_pkg::K_HEREDOC;
    endcase
  endfunction

  function automatic logic [7:0] op_char(sct_pkg::op_t op);
    case (op)
      sct_pkg::OP_AMP:  return sct_pkg::CH_AMP;
      sct_pkg::OP_PIPE: return sct_pkg::CH_PIPE;
      sct_pkg::OP_GT:   return sct_pkg::CH_GT;
      sct_pkg::OP_LT:   return sct_pkg::CH_LT;
      default:          return sct_pkg::CH_NUL;
    endcase
  endfunction

  function automatic void flush_pending_op();
    if (lx_op != sct_pkg::OP_NONE)
      put_tok(lone_op_kind(lx_op), 8'h00, 1'b0);
    lx_op = sct_pkg::OP_NONE;
  endfunction

  // line end: dangling backslash, open word, held operator, then eof
  function automatic void close_line();
    if (lx_esc)
      add_word_byte(sct_pkg::CH_BSLASH);
    lx_esc   = 1'b0;
    lx_quote = sct_pkg::Q_NONE;
    close_word();
    flush_pending_op();
    put_tok(sct_pkg::K_EOF, 8'h00, 1'b0);
  endfunction

  function automatic void clear_lexer();
    lx_quote  = sct_pkg::Q_NONE;
    lx_esc    = 1'b0;
    lx_op     = sct_pkg::OP_NONE;
    lx_wopen  = 1'b0;
    lx_wlen   = 0;
    lx_wtrunc = 1'b0;
    lx_skip   = 1'b0;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == sct_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    // single quotes copy everything up to the closing quote
    if (lx_quote == sct_pkg::Q_SINGLE) begin
      if (c == sct_pkg::CH_SQUOTE)
        lx_quote = sct_pkg::Q_NONE;
      else
        add_word_byte(c);
      return;
    end
    // double quotes let a backslash copy the next byte
    if (lx_quote == sct_pkg::Q_DOUBLE) begin
      if (lx_esc) begin
        add_word_byte(c);
        lx_esc = 1'b0;
      end else if (c == sct_pkg::CH_BSLASH) begin
        lx_esc = 1'b1;
      end else if (c == sct_pkg::CH_DQUOTE) begin
        lx_quote = sct_pkg::Q_NONE;
      end else begin
        add_word_byte(c);
      end
      return;
    end
    if (lx_esc) begin
      add_word_byte(c);
      lx_esc = 1'b0;
      return;
    end
    // held operator: same byte again makes the two-byte form
    if (lx_op != sct_pkg::OP_NONE) begin
      if (c == op_char(lx_op)) begin
        put_tok(paired_op_kind(lx_op), 8'h00, 1'b0);
        lx_op = sct_pkg::OP_NONE;
        return;
      end
      flush_pending_op();
    end
    if (is_blank(c)) begin
      close_word();
    end else if (c == sct_pkg::CH_SEMI || c == sct_pkg::CH_LPAR || c == sct_pkg::CH_RPAR) begin
      close_word();
      put_tok(c == sct_pkg::CH_SEMI ? sct_pkg::K_SEMI :
              (c == sct_pkg::CH_LPAR ? sct_pkg::K_LPAR : sct_pkg::K_RPAR), 8'h00, 1'b0);
    end else if (c == sct_pkg::CH_AMP || c == sct_pkg::CH_PIPE || c == sct_pkg::CH_GT ||
                 c == sct_pkg::CH_LT) begin
      close_word();
      lx_op = (c == sct_pkg::CH_AMP)  ? sct_pkg::OP_AMP  :
              (c == sct_pkg::CH_PIPE) ? sct_pkg::OP_PIPE :
              (c == sct_pkg::CH_GT)   ? sct_pkg::OP_GT   : sct_pkg::OP_LT;
    end else if (c == sct_pkg::CH_SQUOTE) begin
      lx_wopen = 1'b1;
      lx_quote = sct_pkg::Q_SINGLE;
    end else if (c == sct_pkg::CH_DQUOTE) begin
      lx_wopen = 1'b1;
      lx_quote = sct_pkg::Q_DOUBLE;
    end else if (c == sct_pkg::CH_BSLASH) begin
      lx_wopen = 1'b1;
      lx_esc   = 1'b1;
    end else begin
      add_word_byte(c);
    end
  endfunction

  function automatic void lex_item(logic [7:0] c, logic cv, logic le);
    item_toks.delete();
    if (lx_skip) begin
      if (le)
        clear_lexer();
      return;
    end
    if (cv && c == sct_pkg::CH_NUL) begin
      // a nul byte closes the line now; the rest waits for line_end
      close_line();
      clear_lexer();
      if (!le)
        lx_skip = 1'b1;
    end else begin
      if (cv)
        lex_byte(c);
      if (le) begin
        close_line();
        clear_lexer();
      end
    end
  endfunction

  // predict an accepted item and queue its tokens; known rows queue their typed tokens
  function automatic void record_item(row_t r);
    token_t t;
    lex_item(r.c, r.cv, r.le);
    if (r.known) begin
      item_toks.delete();
      if (r.nknown > 0)
        item_toks.push_back(r.k0);
      if (r.nknown > 1)
        item_toks.push_back(r.k1);
    end
    foreach (item_toks[i]) begin
      t.tok  = item_toks[i];
      t.last = (i == item_toks.size() - 1);
      tokens_due.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  function automatic row_t line_item(logic [7:0] c, logic cv, logic le);
    row_t r;
    r        = '0;
    r.c      = c;
    r.cv     = cv;
    r.le     = le;
    return r;
  endfunction

  function automatic row_t known_item(logic [7:0] c, logic cv, logic le, int n,
                                      sct_pkg::tok_t a, sct_pkg::tok_t b);
    row_t r;
    r        = line_item(c, cv, le);
    r.known  = 1'b1;
    r.nknown = n[1:0];
    r.k0     = a;
    r.k1     = b;
    return r;
  endfunction

  // letters mostly, some punctuation, digits and high bytes
  function automatic logic [7:0] pick_word_char();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 8'($urandom_range(128, 255));
      1:       return 8'($urandom_range(8'h30, 8'h39));
      2:       return 8'($urandom_range(8'h2d, 8'h2f));
      default: return 8'($urandom_range(8'h61, 8'h7a));
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    int r;
    r = $urandom_range(0, 6);
    return (r < 5) ? 8'(9 + r) : sct_pkg::CH_SPACE;
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 6))
      0:       return sct_pkg::CH_AMP;
      1:       return sct_pkg::CH_PIPE;
      2:       return sct_pkg::CH_SEMI;
      3:       return sct_pkg::CH_LPAR;
      4:       return sct_pkg::CH_RPAR;
      5:       return sct_pkg::CH_GT;
      default: return sct_pkg::CH_LT;
    endcase
  endfunction

  // any nonzero byte that does not end the quoted run
  function automatic logic [7:0] pick_quoted(logic [7:0] term);
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    if (b == term || (term == sct_pkg::CH_DQUOTE && b == sct_pkg::CH_BSLASH))
      b = "q";
    return b;
  endfunction

  // a line byte, now and then followed by an empty item
  function automatic void push_byte(logic [7:0] b);
    line_q.push_back(line_item(b, 1'b1, 1'b0));
    if ($urandom_range(0, 11) == 0)
      line_q.push_back(line_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
  endfunction

  // one word longer than the bound, closed by a blank or by line end
  function automatic void build_long_line(bit blank_end);
    line_q.delete();
    repeat (sct_pkg::MAX_WORD + $urandom_range(1, 30))
      line_q.push_back(line_item(pick_word_char(), 1'b1, 1'b0));
    if (blank_end) begin
      line_q.push_back(line_item(sct_pkg::CH_SPACE, 1'b1, 1'b0));
      line_q.push_back(line_item("w", 1'b1, 1'b0));
    end
    line_q[line_q.size() - 1].le = 1'b1;
  endfunction

  // mostly well-formed lines built from words, quotes, escapes and operators;
  // some lines leave a quote or a backslash open, a few are plain noise
  function automatic void build_random_line();
    int         pieces;
    int         ending;
    bit         broken;
    bit         tail;
    logic [7:0] b;
    line_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12))
        line_q.push_back(line_item(8'($urandom_range(0, 255)),
                                   $urandom_range(0, 7) != 0, 1'b0));
      line_q.push_back(line_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1));
      return;
    end
    broken = ($urandom_range(0, 4) == 0);
    pieces = $urandom_range(1, 6);
    for (int p = 0; p < pieces; p++) begin
      tail = broken && (p == pieces - 1);
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 5)) push_byte(pick_word_char());
        3: push_byte(pick_blank());
        4: begin
          b = pick_op();
          push_byte(b);
          if ($urandom_range(0, 1) != 0)
            push_byte(b);
        end
        5: begin
          push_byte(sct_pkg::CH_SQUOTE);
          repeat ($urandom_range(0, 3)) push_byte(pick_quoted(sct_pkg::CH_SQUOTE));
          if (!tail)
            push_byte(sct_pkg::CH_SQUOTE);
        end
        6: begin
          push_byte(sct_pkg::CH_DQUOTE);
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 3) == 0) begin
              push_byte(sct_pkg::CH_BSLASH);
              push_byte(8'($urandom_range(1, 255)));
            end else begin
              push_byte(pick_quoted(sct_pkg::CH_DQUOTE));
            end
          end
          if (!tail)
            push_byte(sct_pkg::CH_DQUOTE);
        end
        7: begin
          push_byte(sct_pkg::CH_BSLASH);
          if (!tail)
            push_byte(8'($urandom_range(1, 255)));
        end
        default: push_byte(pick_word_char());
      endcase
    end
    ending = $urandom_range(0, 3);
    if (ending == 0) begin
      // separate empty end item
      line_q.push_back(line_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    end else if (ending == 1) begin
      // nul byte ends the line early, junk until the line_end item
      tail = ($urandom_range(0, 3) == 0);
      line_q.push_back(line_item(sct_pkg::CH_NUL, 1'b1, tail));
      if (!tail) begin
        repeat ($urandom_range(0, 2))
          line_q.push_back(line_item(8'($urandom_range(0, 255)),
                                     1'($urandom_range(0, 1)), 1'b0));
        line_q.push_back(line_item(8'($urandom_range(0, 255)),
                                   1'($urandom_range(0, 1)), 1'b1));
      end
    end else begin
      line_q[line_q.size() - 1].le = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_row(row_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_if.valid      <= 1'b1;
    char_if.char_in    <= r.c;
    char_if.char_valid <= r.cv;
    char_if.line_end   <= r.le;
    @(posedge clk);
    while (!char_if.ready)
      @(posedge clk);
    record_item(r);
    @(negedge clk);
  endtask

  task automatic send_line();
    no_idle = ($urandom_range(0, 4) == 0);
    foreach (line_q[i])
      send_row(line_q[i]);
  endtask

  // hold the sender until every queued token has come out
  task automatic drain_tokens();
    char_if.valid <= 1'b0;
    while (tokens_due.size() != 0)
      @(negedge clk);
  endtask

  // receiver: after each token it stays busy for a random number of cycles
  initial begin : token_sink
    tok_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        tok_if.ready <= 1'b0;
        sink_hold = sink_hold - 1;
      end else begin
        tok_if.ready <= 1'b1;
      end
    end
  end

  // compare every token against the oldest expectation
  always @(posedge clk) begin : token_check
    token_t want;
    if (!rst && tok_if.valid && tok_if.ready) begin
      sink_hold = no_idle ? 0 : $urandom_range(0, 9);
      if (tokens_due.size() == 0) begin
        report_mismatch("unexpected token kind", 8'(tok_if.kind), 8'h00);
      end else begin
        want = tokens_due.pop_front();
        if (tok_if.kind !== want.tok.kind)
          report_mismatch("kind", 8'(tok_if.kind), 8'(want.tok.kind));
        if (tok_if.char_out !== want.tok.ch)
          report_mismatch("char_out", tok_if.char_out, want.tok.ch);
        if (tok_if.truncated !== want.tok.trunc)
          report_mismatch("truncated", 8'(tok_if.truncated), 8'(want.tok.trunc));
        if (tok_if.last !== want.last)
          report_mismatch("last", 8'(tok_if.last), 8'(want.last));
      end
    end
  end

  // a hung handshake on either side ends the run
  always @(posedge clk) begin
    if (rst || (char_if.valid && char_if.ready) || (tok_if.valid && tok_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    row_t dir_q[$];
    int   rand_items;

    char_if.valid      = 1'b0;
    char_if.char_in    = 8'h00;
    char_if.char_valid = 1'b0;
    char_if.line_end   = 1'b0;
    rand_items         = 0;
    clear_lexer();

    repeat (3) @(negedge clk);
    rst = 1'b0;

    // directed: every token kind, field extremes and the corner cases
    // empty line right after reset is a bare eof
    dir_q.push_back(known_item(sct_pkg::CH_NUL, 1'b0, 1'b1, 1,
                               tok(sct_pkg::K_EOF, 8'h00, 1'b0), NO_TOK));
    // empty item without line end does nothing
    dir_q.push_back(known_item(sct_pkg::CH_NUL, 1'b0, 1'b0, 0, NO_TOK, NO_TOK));
    // high byte is an ordinary word byte
    dir_q.push_back(known_item(8'hff, 1'b1, 1'b0, 1,
                               tok(sct_pkg::K_WBYTE, 8'hff, 1'b0), NO_TOK));
    dir_q.push_back(known_item(sct_pkg::CH_SPACE, 1'b1, 1'b0, 1,
                               tok(sct_pkg::K_WEND, 8'h00, 1'b0), NO_TOK));
    // operator pairs and singles, each decided by the following byte
    dir_q.push_back(known_item(sct_pkg::CH_AMP, 1'b1, 1'b0, 0, NO_TOK, NO_TOK));
    dir_q.push_back(known_item(sct_pkg::CH_AMP, 1'b1, 1'b0, 1,
                               tok(sct_pkg::K_AND, 8'h00, 1'b0), NO_TOK));
    dir_q.push_back(known_item(sct_pkg::CH_AMP, 1'b1, 1'b0, 0, NO_TOK, NO_TOK));
    dir_q.push_back(known_item(sct_pkg::CH_PIPE, 1'b1, 1'b0, 1,
                               tok(sct_pkg::K_AMP, 8'h00, 1'b0), NO_TOK));
    dir_q.push_back(known_item(sct_pkg::CH_PIPE, 1'b1, 1'b0, 1,
                               tok(sct_pkg::K_OR, 8'h00, 1'b0), NO_TOK));
    dir_q.push_back(known_item(sct_pkg::CH_PIPE, 1'b1, 1'b0, 0, NO_TOK, NO_TOK));
    dir_q.push_back(known_item(sct_pkg::CH_GT, 1'b1, 1'b0, 1,
                               tok(sct_pkg::K_PIPE, 8'h00, 1'b0), NO_TOK));
    dir_q.push_back(known_item(sct_pkg::CH_GT, 1'b1, 1'b0, 1,
                               tok(sct_pkg::K_GTGT, 8'h00, 1'b0), NO_TOK));
    dir_q.push_back(known_item(sct_pkg::CH_LT, 1'b1, 1'b0, 0, NO_TOK, NO_TOK));
    dir_q.push_back(known_item(sct_pkg::CH_LT, 1'b1, 1'b0, 1,
                               tok(sct_pkg::K_HEREDOC, 8'h00, 1'b0), NO_TOK));
    dir_q.push_back(known_item(sct_pkg::CH_GT, 1'b1, 1'b0, 0, NO_TOK, NO_TOK));
    dir_q.push_back(line_item(sct_pkg::CH_SEMI, 1'b1, 1'b0));
    dir_q.push_back(line_item(sct_pkg::CH_LPAR, 1'b1, 1'b0));
    dir_q.push_back(line_item(sct_pkg::CH_RPAR, 1'b1, 1'b0));
    // held operator flushes in its single form at line end
    dir_q.push_back(known_item(sct_pkg::CH_LT, 1'b1, 1'b1, 2,
                               tok(sct_pkg::K_LT, 8'h00, 1'b0),
                               tok(sct_pkg::K_EOF, 8'h00, 1'b0)));
    // empty quotes still open a word; a dangling backslash becomes a byte
    dir_q.push_back(line_item(sct_pkg::CH_SQUOTE, 1'b1, 1'b0));
    dir_q.push_back(line_item(sct_pkg::CH_SQUOTE, 1'b1, 1'b0));
    dir_q.push_back(line_item(sct_pkg::CH_BSLASH, 1'b1, 1'b0));
    dir_q.push_back(line_item(sct_pkg::CH_NUL, 1'b0, 1'b1));
    // nul byte closes the line early, the rest is ignored up to line end
    dir_q.push_back(known_item(sct_pkg::CH_NUL, 1'b1, 1'b0, 1,
                               tok(sct_pkg::K_EOF, 8'h00, 1'b0), NO_TOK));
    dir_q.push_back(line_item("q", 1'b1, 1'b0));
    dir_q.push_back(known_item(sct_pkg::CH_NUL, 1'b0, 1'b1, 0, NO_TOK, NO_TOK));
    foreach (dir_q[i])
      send_row(dir_q[i]);

    // sender waits here until the output side has caught up
    drain_tokens();

    // words past the length bound, ended by a blank and by line end
    build_long_line(1'b1);
    send_line();
    build_long_line(1'b0);
    send_line();

    // random lines, with both sides idling per line
    while (rand_items < RANDOM_ITEMS) begin
      build_random_line();
      foreach (line_q[i])
        if (line_q[i].cv || line_q[i].le)
          rand_items++;
      send_line();
    end

    drain_tokens();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (tokens_due.size() != 0)
      err_count++;
    if (err_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: shell_command_tokenizer.f
rtl/sct_pkg.sv
rtl/sct_in_if.sv
rtl/sct_out_if.sv
rtl/sct_front.sv
rtl/sct_queue.sv
rtl/sct_back.sv
rtl/shell_command_tokenizer.sv
bench/tb_shell_command_tokenizer.sv
